FILE: src/ptrr_pkg.sv
// Package for the page translate / random replace core: constants, types, helpers.
// No dependencies; imported by every module under src except ptrr_ram.
package ptrr_pkg;

    localparam int unsigned DEF_MAX_PAGES  = 1024;
    localparam int unsigned DEF_MAX_FRAMES = 256;
    localparam int unsigned DEF_ADDR_BITS  = 32;

    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 17;

    localparam logic [CFG_IDX_W-1:0] REG_PAGE_SIZE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PAGES_USE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FRAMES_USE  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RANDOM_SEED = 2'd3;

    localparam logic [16:0] PSZ_RESET    = 17'd4096;
    localparam logic [16:0] PSZ_MAX      = 17'd65536;
    localparam logic [10:0] PAGES_RESET  = 11'd1024;
    localparam logic [8:0]  FRAMES_RESET = 9'd256;
    localparam logic [15:0] SEED_RESET   = 16'd44257;
    localparam logic [15:0] LFSR_TAPS    = 16'hB400;

    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;

    // Back-end sequencer
    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_DIV, S_CHECK, S_PRD, S_PICK, S_OWN_RD, S_VICTIM, S_VDIRTY,
        S_MUL, S_DONE
    } t_state;

    function automatic logic [15:0] lfsr_next(input logic [15:0] v);
        lfsr_next = v[0] ? ((v >> 1) ^ LFSR_TAPS) : (v >> 1);
    endfunction

endpackage

FILE: src/ptrr_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module ptrr_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: src/ptrr_front.sv
// Front end: takes commands, classifies the opcode, holds a two-entry command queue.
// Depends on ptrr_pkg.
module ptrr_front #(
    parameter int unsigned ADDR_BITS = ptrr_pkg::DEF_ADDR_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [ADDR_BITS-1:0] i_vaddr,
    input  logic [1:0]           i_opcode,
    input  logic                 i_pop,
    input  logic                 i_hold,
    output logic                 o_busy,
    output logic                 o_avail,
    output logic [ADDR_BITS-1:0] o_vaddr,
    output logic                 o_is_read,
    output logic                 o_is_write
);
    import ptrr_pkg::*;

    logic [ADDR_BITS-1:0] r_addr [2];
    logic [1:0]           r_rd;
    logic [1:0]           r_wr;
    logic                 r_wp, r_rp;
    logic [1:0]           r_cnt;
    logic                 push, pop;

    // held off while the queue is full or the back end clears its tables
    assign o_busy  = (r_cnt == 2'd2) || i_hold;
    assign push    = i_start && !o_busy;
    assign pop     = i_pop && (r_cnt != 2'd0);
    assign o_avail = (r_cnt != 2'd0);
    assign o_vaddr    = r_addr[r_rp];
    assign o_is_read  = r_rd[r_rp];
    assign o_is_write = r_wr[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= !r_wp;
            if (pop)  r_rp <= !r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
        if (push) begin
            r_addr[r_wp] <= i_vaddr;
            r_rd[r_wp]   <= (i_opcode == OP_READ);
            r_wr[r_wp]   <= (i_opcode == OP_WRITE);
        end
    end

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3) else $error("queue count overflow");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0) |=> (r_cnt <= 2'd1)) else $error("queue grew by two");
    a_ptr_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0 || r_cnt == 2'd2) |-> (r_wp == r_rp))
        else $error("queue pointers out of step");
endmodule

FILE: src/ptrr_back.sv
// Back end: divider, page tables, replacement and result generation.
// Depends on ptrr_pkg and ptrr_ram.
module ptrr_back #(
    parameter int unsigned MAX_PAGES  = ptrr_pkg::DEF_MAX_PAGES,
    parameter int unsigned MAX_FRAMES = ptrr_pkg::DEF_MAX_FRAMES,
    parameter int unsigned ADDR_BITS  = ptrr_pkg::DEF_ADDR_BITS,
    localparam int unsigned PW = $clog2(MAX_PAGES),
    localparam int unsigned FW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_avail,
    input  logic [ADDR_BITS-1:0] i_vaddr,
    input  logic                 i_is_read,
    input  logic                 i_is_write,
    output logic                 o_pop,
    output logic                 o_clearing,
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_idx,
    input  logic [16:0]          i_cfg_data,
    output logic                 o_done,
    output logic [ADDR_BITS-1:0] o_phys_addr,
    output logic                 o_illegal,
    output logic                 o_fault,
    output logic                 o_replaced,
    output logic [PW-1:0]        o_victim_page,
    output logic                 o_wrote_back,
    output logic [31:0]          o_read_total,
    output logic [31:0]          o_write_total,
    output logic [31:0]          o_fault_total,
    output logic [31:0]          o_writeback_total,
    output logic [31:0]          o_illegal_total
);
    import ptrr_pkg::*;

    localparam int unsigned DCW = $clog2(ADDR_BITS + 1);
    localparam int unsigned CW  = $clog2(MAX_FRAMES + 1);
    // page table entry: present, dirty, frame
    localparam int unsigned PTW  = FW + 2;
    localparam int unsigned PT_P = FW + 1;
    localparam int unsigned PT_D = FW;

    // configuration
    logic [16:0] r_psz_cfg;
    logic [10:0] r_pages_cfg;
    logic [8:0]  r_frames_cfg;

    // effective values
    logic [16:0] eff_psz;
    logic [16:0] eff_pages;
    logic [16:0] eff_frames;
    always_comb begin
        eff_psz = (r_psz_cfg == '0) ? 17'd1 : ((r_psz_cfg > PSZ_MAX) ? PSZ_MAX : r_psz_cfg);
        eff_pages = ({6'd0, r_pages_cfg} > 17'(MAX_PAGES)) ? 17'(MAX_PAGES)
                                                             : {6'd0, r_pages_cfg};
        eff_frames = (r_frames_cfg == '0) ? 17'd1
                   : (({8'd0, r_frames_cfg} > 17'(MAX_FRAMES)) ? 17'(MAX_FRAMES)
                                                              : {8'd0, r_frames_cfg});
    end

    t_state r_state, n_state;

    logic [ADDR_BITS-1:0] r_quo;
    logic [16:0]          r_rem;
    logic [DCW-1:0]       r_dcnt;
    logic                 r_rd, r_wr;
    logic [PW-1:0]        r_page;
    logic [FW-1:0]        r_frame;
    logic [PW-1:0]        r_victim;
    logic                 r_fault, r_repl, r_wb, r_illegal, r_old_dirty;
    logic [CW-1:0]        r_next_free;
    logic [15:0]          r_lfsr;
    logic [31:0]          r_reads, r_writes, r_faults, r_wbs, r_ills;
    logic [ADDR_BITS-1:0] r_phys;
    logic [PW-1:0]        r_clr_addr;

    // page table and frame_owner memories
    logic           pt_we;
    logic [PW-1:0]  pt_waddr, pt_raddr;
    logic [PTW-1:0] pt_wdata, pt_rdata;
    logic           fo_we;
    logic [PW-1:0]  fo_rdata;

    ptrr_ram #(.WIDTH(PTW), .DEPTH(MAX_PAGES)) u_page_table (
        .i_clk(i_clk), .i_we(pt_we), .i_waddr(pt_waddr), .i_wdata(pt_wdata),
        .i_raddr(pt_raddr), .o_rdata(pt_rdata)
    );
    ptrr_ram #(.WIDTH(PW), .DEPTH(MAX_FRAMES)) u_frame_owner (
        .i_clk(i_clk), .i_we(fo_we), .i_waddr(r_frame), .i_wdata(r_page),
        .i_raddr(r_frame), .o_rdata(fo_rdata)
    );

    // restoring divider step: one quotient bit a cycle
    logic [17:0] trial;
    assign trial = {r_rem, r_quo[ADDR_BITS-1]} - {1'b0, eff_psz};

    logic [15:0] lfsr_stepped;
    logic [32:0] pick_prod;
    logic [FW-1:0] pick;
    assign lfsr_stepped = lfsr_next(r_lfsr);
    assign pick_prod = {1'b0, lfsr_stepped} * eff_frames;
    assign pick = (pick_prod[32:16] >= 17'(MAX_FRAMES)) ? FW'(MAX_FRAMES - 1)
                                                        : pick_prod[16+FW-1:16];

    // quotient is the page number once the divider finishes
    logic illegal_now, miss_now;
    assign illegal_now = ({17'd0, r_quo} >= (ADDR_BITS+17)'(eff_pages));
    assign miss_now    = !r_illegal && !pt_rdata[PT_P];

    // frame * page_size + offset; r_rem still holds the offset
    logic [FW+17:0] phys_sum;
    assign phys_sum = (FW+18)'(r_frame) * (FW+18)'(eff_psz) + (FW+18)'(r_rem);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR:  if (r_clr_addr == PW'(MAX_PAGES - 1)) n_state = S_IDLE;
            S_IDLE:   if (i_avail) n_state = S_DIV;
            S_DIV:    if (r_dcnt == DCW'(1)) n_state = S_CHECK;
            S_CHECK:  n_state = S_PRD;
            S_PRD:    n_state = S_PICK;
            S_PICK:   n_state = S_OWN_RD;
            S_OWN_RD: n_state = S_VICTIM;
            S_VICTIM: n_state = S_VDIRTY;
            S_VDIRTY: n_state = S_MUL;
            S_MUL:    n_state = S_DONE;
            S_DONE:   n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_pop      = (r_state == S_IDLE) && i_avail;
        o_clearing = (r_state == S_CLEAR);
        fo_we      = (r_state == S_VICTIM) && r_fault;
        o_done     = (r_state == S_DONE);
        pt_we      = 1'b0;
        pt_waddr   = r_page;
        pt_wdata   = '0;
        unique case (r_state)
            S_CLEAR: begin
                pt_we    = 1'b1;
                pt_waddr = r_clr_addr;
            end
            S_VDIRTY: begin
                pt_we    = r_repl;
                pt_waddr = r_victim;
            end
            S_MUL: begin
                pt_we    = !r_illegal;
                pt_wdata = {1'b1, (r_old_dirty && !r_fault) || r_wr, r_frame};
            end
            default: ;
        endcase
        // victim entry is read while its owner comes out of frame_owner
        pt_raddr = ((r_state == S_VICTIM) && r_repl) ? fo_rdata : r_page;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_clr_addr   <= '0;
            r_psz_cfg    <= PSZ_RESET;
            r_pages_cfg  <= PAGES_RESET;
            r_frames_cfg <= FRAMES_RESET;
            r_lfsr       <= SEED_RESET;
            r_next_free  <= '0;
            r_reads      <= '0;
            r_writes     <= '0;
            r_faults     <= '0;
            r_wbs        <= '0;
            r_ills       <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_PAGE_SIZE:   r_psz_cfg    <= i_cfg_data;
                    REG_PAGES_USE:   r_pages_cfg  <= i_cfg_data[10:0];
                    REG_FRAMES_USE:  r_frames_cfg <= i_cfg_data[8:0];
                    REG_RANDOM_SEED: ;   // seed writes are ignored; reset loads the LFSR with SEED_RESET
                    default: ;
                endcase
            end
            case (r_state)
                S_CLEAR: r_clr_addr <= r_clr_addr + PW'(1);
                S_CHECK: begin
                    if (illegal_now) r_ills <= r_ills + 32'd1;
                end
                S_PICK: begin
                    if (miss_now) begin
                        r_faults <= r_faults + 32'd1;
                        if (17'(r_next_free) < eff_frames) begin
                            r_next_free <= r_next_free + CW'(1);
                        end else begin
                            r_lfsr <= lfsr_stepped;
                        end
                    end
                end
                S_VDIRTY: begin
                    if (r_repl && pt_rdata[PT_D]) r_wbs <= r_wbs + 32'd1;
                end
                S_MUL: begin
                    if (!r_illegal) begin
                        if (r_rd) r_reads <= r_reads + 32'd1;
                        if (r_wr) r_writes <= r_writes + 32'd1;
                    end
                end
                default: ;
            endcase
        end
        // payload path
        case (r_state)
            S_IDLE: begin
                r_quo  <= i_vaddr;
                r_rem  <= '0;
                r_dcnt <= DCW'(ADDR_BITS);
                r_rd   <= i_is_read;
                r_wr   <= i_is_write;
                r_repl <= 1'b0;
                r_wb   <= 1'b0;
                r_victim <= '0;
            end
            S_DIV: begin
                r_dcnt <= r_dcnt - DCW'(1);
                if (!trial[17]) begin
                    r_rem <= trial[16:0];
                    r_quo <= {r_quo[ADDR_BITS-2:0], 1'b1};
                end else begin
                    r_rem <= {r_rem[15:0], r_quo[ADDR_BITS-1]};
                    r_quo <= {r_quo[ADDR_BITS-2:0], 1'b0};
                end
            end
            S_CHECK: begin
                r_illegal <= illegal_now;
                r_page    <= r_quo[PW-1:0];
            end
            S_PICK: begin
                r_fault     <= miss_now;
                r_old_dirty <= pt_rdata[PT_D];
                if (miss_now) begin
                    if (17'(r_next_free) < eff_frames) begin
                        r_frame <= r_next_free[FW-1:0];
                    end else begin
                        r_frame <= pick;
                        r_repl  <= 1'b1;
                    end
                end else begin
                    r_frame <= pt_rdata[FW-1:0];
                end
            end
            S_VICTIM: begin
                if (r_repl) r_victim <= fo_rdata;
            end
            S_VDIRTY: begin
                if (r_repl) r_wb <= pt_rdata[PT_D];
            end
            S_MUL: begin
                r_phys <= r_illegal ? '1 : ADDR_BITS'(phys_sum);
            end
            default: ;
        endcase
    end

    assign o_phys_addr       = r_phys;
    assign o_illegal         = r_illegal;
    assign o_fault           = r_fault;
    assign o_replaced        = r_repl;
    assign o_victim_page     = r_victim;
    assign o_wrote_back      = r_wb;
    assign o_read_total      = r_reads;
    assign o_write_total     = r_writes;
    assign o_fault_total     = r_faults;
    assign o_writeback_total = r_wbs;
    assign o_illegal_total   = r_ills;

    a_repl_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_replaced |-> o_fault) else $error("eviction without fault");
    a_ill_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_illegal |-> !o_fault && !o_replaced)
        else $error("illegal access touched tables");
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("result strobe longer than a cycle");
    a_free_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_next_free <= CW'(MAX_FRAMES)) else $error("free frame count overrun");
endmodule

FILE: src/page_translate_random_replace_core.sv
// Top level of the demand-paging translator with random frame replacement.
// Depends on ptrr_pkg, ptrr_front, ptrr_back (and ptrr_ram through ptrr_back).
//
// Each command carries a virtual address and an opcode (read, write, other).
// A transfer happens when start is high and busy is low. After reset the
// page table is cleared one entry a cycle, so busy stays high until all
// MAX_PAGES entries (1024 by default) are cleared; after that busy rises
// only when the two-entry command queue is full. The back end takes one
// command at a time: restoring division by page_size, then table lookup,
// frame pick, frame_owner and victim lookup, table update and the
// frame*page_size+offset sum; it then returns to idle, where it takes the
// next command, so it cannot start a command before the last one is done.
// The result sits on the o_ ports for exactly one cycle, flagged by o_valid;
// the receiver cannot stall it. Counters on the result are the running
// totals after that access and wrap at 32 bits.
// Configuration writes (i_cfg_we/i_cfg_idx/i_cfg_data) take effect at once,
// but for a seed write, which is ignored, and are only to be made while no
// command is outstanding.
module page_translate_random_replace_core #(
    parameter int unsigned MAX_PAGES  = ptrr_pkg::DEF_MAX_PAGES,
    parameter int unsigned MAX_FRAMES = ptrr_pkg::DEF_MAX_FRAMES,
    parameter int unsigned ADDR_BITS  = ptrr_pkg::DEF_ADDR_BITS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [ADDR_BITS-1:0]            i_virtual_addr,
    input  logic [1:0]                      i_opcode,
    input  logic                            i_cfg_we,
    input  logic [ptrr_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [ptrr_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic                            o_valid,
    output logic [ADDR_BITS-1:0]            o_phys_addr,
    output logic                            o_illegal,
    output logic                            o_fault,
    output logic                            o_replaced,
    output logic [$clog2(MAX_PAGES)-1:0]    o_victim_page,
    output logic                            o_wrote_back,
    output logic [31:0]                     o_read_total,
    output logic [31:0]                     o_write_total,
    output logic [31:0]                     o_fault_total,
    output logic [31:0]                     o_writeback_total,
    output logic [31:0]                     o_illegal_total
);
    import ptrr_pkg::*;

    logic                 q_avail, q_pop, q_rd, q_wr, clearing;
    logic [ADDR_BITS-1:0] q_vaddr;

    ptrr_front #(.ADDR_BITS(ADDR_BITS)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start),
        .i_vaddr(i_virtual_addr), .i_opcode(i_opcode), .i_pop(q_pop),
        .i_hold(clearing), .o_busy(busy), .o_avail(q_avail), .o_vaddr(q_vaddr),
        .o_is_read(q_rd), .o_is_write(q_wr)
    );

    ptrr_back #(.MAX_PAGES(MAX_PAGES), .MAX_FRAMES(MAX_FRAMES),
                .ADDR_BITS(ADDR_BITS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_avail(q_avail),
        .i_vaddr(q_vaddr), .i_is_read(q_rd), .i_is_write(q_wr), .o_pop(q_pop),
        .o_clearing(clearing),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .o_done(o_valid), .o_phys_addr(o_phys_addr),
        .o_illegal(o_illegal), .o_fault(o_fault),
        .o_replaced(o_replaced), .o_victim_page(o_victim_page),
        .o_wrote_back(o_wrote_back), .o_read_total(o_read_total),
        .o_write_total(o_write_total), .o_fault_total(o_fault_total),
        .o_writeback_total(o_writeback_total), .o_illegal_total(o_illegal_total)
    );
endmodule
